FILE: design/vsf_pkg.sv
// Shared constants, register indexes and widths for the voxel sphere fill scanner.
package vsf_pkg;

  localparam int BLOCK_SIZE    = 32;
  localparam int BLOCK_OVERLAP = 2;
  localparam int FULL          = BLOCK_SIZE + BLOCK_OVERLAP;
  // block-local coordinate width: holds 0 .. FULL
  localparam int POS_W         = $clog2(FULL + 1);
  // output coordinate field width
  localparam int OUT_W         = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;

  // center (32) divided then offset by a 27-bit block times BLOCK_SIZE
  localparam int CEN_W = 34;
  // center +/- radius
  localparam int EXT_W = CEN_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_RADIUS    = 3'd3,
    REG_DENSITY   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } item_kind_t;

endpackage

FILE: design/voxel_sphere_fill_scanner_core.sv
// Sphere fill scanner: start beats set up a clipped voxel box, tick beats walk it.
// Each accepted input beat yields one result beat on m_axis.
// Throughput: one beat per cycle, start or tick, unless m_axis stalls; only the scan
//   counters and start setup (scaled center, clipped range) carry over to the next beat.
// Distance test runs in two pipeline stages after the input stage (squares, then sum
//   and compare); a stalled m_axis backs up through the three pipeline registers.
// Reset (rst, synchronous): scan idle, pipeline empty, all config registers zero.
module voxel_sphere_fill_scanner_core (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [vsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vsf_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // lod[3:0], block_x[30:4], block_y[57:31], block_z[84:58], zero pad
  input  logic [vsf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind[0]
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // voxel_x[5:0], voxel_y[11:6], voxel_z[17:12], density_out[25:18], zero pad
  output logic [vsf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // write_enable[0]
  output logic                              m_axis_tuser,
  // done_res
  output logic                              m_axis_tlast
);
  import vsf_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] cfg_center [3];
  logic [15:0]        cfg_radius;
  logic [7:0]         cfg_density;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_center[0] <= '0;
      cfg_center[1] <= '0;
      cfg_center[2] <= '0;
      cfg_radius    <= '0;
      cfg_density   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: cfg_center[0] <= cfg_data;
        REG_CENTER_Y: cfg_center[1] <= cfg_data;
        REG_CENTER_Z: cfg_center[2] <= cfg_data;
        REG_RADIUS:   cfg_radius    <= cfg_data[15:0];
        REG_DENSITY:  cfg_density   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves when the one after it is empty
  // or moving, so bubbles are squeezed out under output backpressure.
  // ---------------------------------------------------------------------------
  logic p1_valid, p2_valid;
  logic p2_move, p1_move, in_acc;

  assign p2_move       = !m_axis_tvalid || m_axis_tready;
  assign p1_move       = !p2_valid || p2_move;
  assign s_axis_tready = !p1_valid || p1_move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------------------
  logic signed [CEN_W-1:0] loc_c [3];   // block-local scaled center
  logic [15:0]             scaled_radius;
  logic [POS_W-1:0]        rng_lo [3];  // clipped box, lower inclusive
  logic [POS_W-1:0]        rng_hi [3];  // clipped box, upper exclusive
  logic [POS_W-1:0]        pos [3];     // next voxel to visit
  logic                    scan_active;

  // input beat fields
  logic [3:0]         in_lod;
  logic signed [26:0] in_blk [3];
  item_kind_t         in_kind;

  assign in_lod    = s_axis_tdata[3:0];
  assign in_blk[0] = s_axis_tdata[30:4];
  assign in_blk[1] = s_axis_tdata[57:31];
  assign in_blk[2] = s_axis_tdata[84:58];
  assign in_kind   = item_kind_t'(s_axis_tuser);

  // ---------------------------------------------------------------------------
  // Start setup: divide center by 2^lod toward zero (bias negatives before the
  // arithmetic shift), subtract the block origin, then clip center +/- radius.
  // ---------------------------------------------------------------------------
  logic signed [CEN_W-1:0] st_c [3];
  logic [POS_W-1:0]        st_lo [3];
  logic [POS_W-1:0]        st_hi [3];
  logic [15:0]             st_r;
  logic                    st_active;

  always_comb begin
    logic signed [32:0]      bias;
    logic signed [32:0]      sc;
    logic signed [CEN_W-1:0] org;
    logic signed [EXT_W-1:0] lo;
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] r_ext;
    logic                    reject;
    logic                    empty;
    st_r   = cfg_radius >> in_lod;
    r_ext  = EXT_W'($signed({1'b0, st_r}));
    reject = 1'b0;
    empty  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      bias     = cfg_center[i][31] ? ((33'sd1 <<< in_lod) - 33'sd1) : 33'sd0;
      sc       = (33'(cfg_center[i]) + bias) >>> in_lod;
      org      = CEN_W'(in_blk[i]) * CEN_W'(BLOCK_SIZE);
      st_c[i]  = CEN_W'(sc) - org;
      lo       = EXT_W'(st_c[i]) - r_ext;
      hi       = EXT_W'(st_c[i]) + r_ext;
      if (hi < 0 || lo > EXT_W'(FULL)) begin
        reject = 1'b1;
      end
      st_lo[i] = (lo < 0) ? '0 : lo[POS_W-1:0];
      st_hi[i] = (hi > EXT_W'(FULL)) ? POS_W'(FULL) : hi[POS_W-1:0];
      if (st_lo[i] >= st_hi[i]) begin
        empty = 1'b1;
      end
    end
    st_active = !(reject || empty);
  end

  // ---------------------------------------------------------------------------
  // Tick step: z inner, then y, x outer; wrap of x ends the scan.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] pos_next [3];
  logic             tk_last;

  always_comb begin
    logic [POS_W-1:0] nx, ny, nz;
    nx      = pos[0];
    ny      = pos[1];
    nz      = pos[2] + 1'b1;
    tk_last = 1'b0;
    if (nz >= rng_hi[2]) begin
      nz = rng_lo[2];
      ny = pos[1] + 1'b1;
      if (ny >= rng_hi[1]) begin
        ny = rng_lo[1];
        nx = pos[0] + 1'b1;
        if (nx >= rng_hi[0]) begin
          nx      = rng_lo[0];
          tk_last = 1'b1;
        end
      end
    end
    pos_next[0] = nx;
    pos_next[1] = ny;
    pos_next[2] = nz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
    end else if (in_acc) begin
      if (in_kind == KIND_START) begin
        scan_active <= st_active;
      end else if (scan_active && tk_last) begin
        scan_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_kind == KIND_START) begin
        loc_c         <= st_c;
        scaled_radius <= st_r;
        rng_lo        <= st_lo;
        rng_hi        <= st_hi;
        pos           <= st_lo;
      end else if (scan_active) begin
        pos <= pos_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: per-axis distance magnitude. A magnitude of 2^16 or more already
  // exceeds any radius, so it is flagged as far and its truncated square is ignored.
  // ---------------------------------------------------------------------------
  function automatic logic [16:0] abs_diff(input logic [POS_W-1:0] p,
                                           input logic signed [CEN_W-1:0] c);
    logic signed [EXT_W-1:0] d;
    logic [EXT_W-1:0]        m;
    d = $signed({{(EXT_W-POS_W){1'b0}}, p}) - EXT_W'(c);
    m = d[EXT_W-1] ? EXT_W'(-d) : EXT_W'(d);
    return {(m[EXT_W-1:16] != '0), m[15:0]};
  endfunction

  logic             p1_tick;
  logic             p1_done;
  logic             p1_far;
  logic [15:0]      p1_mag [3];
  logic [15:0]      p1_r;
  logic [7:0]       p1_dens;
  logic [POS_W-1:0] p1_pos [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (p1_move || !p1_valid) begin
      p1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0] ad [3];
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        ad[i]     = abs_diff(pos[i], loc_c[i]);
        p1_mag[i] <= ad[i][15:0];
        p1_pos[i] <= (in_kind == KIND_TICK && scan_active) ? pos[i] : '0;
      end
      p1_far  <= ad[0][16] || ad[1][16] || ad[2][16];
      p1_tick <= (in_kind == KIND_TICK) && scan_active;
      p1_done <= (in_kind == KIND_START) ? !st_active : (!scan_active || tk_last);
      p1_r    <= scaled_radius;
      p1_dens <= cfg_density;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares of the magnitudes and of the radius
  // ---------------------------------------------------------------------------
  logic             p2_tick;
  logic             p2_done;
  logic             p2_far;
  logic [31:0]      p2_sq [3];
  logic [31:0]      p2_r2;
  logic [7:0]       p2_dens;
  logic [POS_W-1:0] p2_pos [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p2_move || !p2_valid) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid && p1_move) begin
      for (int i = 0; i < 3; i++) begin
        p2_sq[i] <= p1_mag[i] * p1_mag[i];
      end
      p2_r2   <= p1_r * p1_r;
      p2_tick <= p1_tick;
      p2_done <= p1_done;
      p2_far  <= p1_far;
      p2_dens <= p1_dens;
      p2_pos  <= p1_pos;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum, compare against r^2, and the output register
  // ---------------------------------------------------------------------------
  logic [33:0] d2;
  logic        hit;

  assign d2  = 34'(p2_sq[0]) + 34'(p2_sq[1]) + 34'(p2_sq[2]);
  assign hit = p2_tick && !p2_far && (d2 < 34'(p2_r2));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (p2_move) begin
      m_axis_tvalid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_valid && p2_move) begin
      m_axis_tuser <= hit;
      m_axis_tlast <= p2_done;
      m_axis_tdata <= {6'b0, (hit ? p2_dens : 8'd0),
                       OUT_W'(p2_pos[2]), OUT_W'(p2_pos[1]), OUT_W'(p2_pos[0])};
    end
  end

endmodule

FILE: design/vsf_checker.sv
// Port-level checks for the voxel sphere fill scanner, bound to the top level.
module vsf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [vsf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);
  import vsf_pkg::*;

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // no write means no density on the bus
  a_no_write_density: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[25:18] == 8'd0)
    else $error("density present without write");

  // a write lands inside the clipped block
  a_write_in_block: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:0] < 6'(FULL)
      && m_axis_tdata[11:6] < 6'(FULL) && m_axis_tdata[17:12] < 6'(FULL))
    else $error("write outside block");

  // pipeline comes out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

  // an idle input side with a free output never sees a stall
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with free output");

endmodule

bind voxel_sphere_fill_scanner_core vsf_checker u_vsf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: test/voxel_sphere_fill_scanner_core_tb.sv
// Self-checking testbench for the voxel sphere fill scanner core: directed and random scans.
`timescale 1ns / 100ps

module voxel_sphere_fill_scanner_core_tb;
  import vsf_pkg::*;

  // generous cycle budget for all scan beats plus the config phases
  localparam int unsigned CYCLE_LIMIT = 200000;
  // idle margin added after each drain
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BUDGET = 110;

  // one input beat, as the core sees it
  typedef struct packed {
    item_kind_t        kind;
    logic [3:0]        lod;
    logic signed [26:0] bx;
    logic signed [26:0] by;
    logic signed [26:0] bz;
  } scan_item_t;

  // one result beat
  typedef struct packed {
    logic             we;
    logic [OUT_W-1:0] vx;
    logic [OUT_W-1:0] vy;
    logic [OUT_W-1:0] vz;
    logic [7:0]       dens;
    logic             done;
  } voxel_write_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  voxel_sphere_fill_scanner_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sphere mirror (register shadow) and scan predictor state
  // ---------------------------------------------------------------------------
  logic signed [31:0]      cfg_center [3] = '{0, 0, 0};
  logic [15:0]             cfg_radius = '0;
  logic [7:0]              cfg_density = '0;

  logic signed [CEN_W-1:0] loc_center [3] = '{0, 0, 0};
  logic [15:0]             scaled_r = '0;
  logic [POS_W-1:0]        box_lo [3] = '{0, 0, 0};
  logic [POS_W-1:0]        box_hi [3] = '{0, 0, 0};
  logic [POS_W-1:0]        scan_pos [3] = '{0, 0, 0};
  bit                      scan_on = 1'b0;

  scan_item_t   pending_items [$];
  voxel_write_t pending_writes [$];

  bit          no_gaps = 1'b0;   // phase without idling on either side
  int          send_gap = 0;
  int          recv_wait = 0;
  int          err_count = 0;
  int unsigned cycle_count = 0;
  scan_item_t  drv_item;
  scan_item_t  mon_item;
  voxel_write_t mon_want;
  voxel_write_t mon_got;
  int          mon_stall;

  // Expected result of one accepted beat; advances the scan state.
  task automatic predict_voxel(input scan_item_t it, output voxel_write_t res);
    longint c [3];
    longint blk [3];
    longint r, lo, hi, q, d, d2, r2;
    bit     reject, empty, wrap_done;
    int     i, px, py, pz;
    res = '0;
    if (it.kind == KIND_START) begin
      blk[0] = longint'(it.bx);
      blk[1] = longint'(it.by);
      blk[2] = longint'(it.bz);
      r = longint'(cfg_radius >> it.lod);
      reject = 1'b0;
      empty = 1'b0;
      for (i = 0; i < 3; i++) begin
        // SV division truncates toward zero, as the scaling requires
        q = longint'(cfg_center[i]) / (longint'(1) << it.lod);
        c[i] = q - blk[i] * BLOCK_SIZE;
        loc_center[i] = CEN_W'(c[i]);
        if (c[i] + r < 0) reject = 1'b1;
        if (c[i] - r > FULL) reject = 1'b1;
      end
      scaled_r = 16'(r);
      for (i = 0; i < 3; i++) begin
        lo = c[i] - r;
        hi = c[i] + r;
        if (lo < 0) lo = 0;
        if (hi > FULL) hi = FULL;
        // only meaningful when the scan goes active, then 0 <= lo < hi <= FULL
        box_lo[i] = POS_W'(lo);
        box_hi[i] = POS_W'(hi);
        scan_pos[i] = POS_W'(lo);
        if (lo >= hi) empty = 1'b1;
      end
      scan_on = !(reject || empty);
      res.done = !scan_on;
    end else if (!scan_on) begin
      res.done = 1'b1;
    end else begin
      d2 = 0;
      for (i = 0; i < 3; i++) begin
        d = longint'(scan_pos[i]) - longint'(loc_center[i]);
        d2 += d * d;
      end
      r2 = longint'(scaled_r) * longint'(scaled_r);
      res.vx = scan_pos[0];
      res.vy = scan_pos[1];
      res.vz = scan_pos[2];
      if (d2 < r2) begin
        res.we = 1'b1;
        res.dens = cfg_density;
      end
      px = int'(scan_pos[0]);
      py = int'(scan_pos[1]);
      pz = int'(scan_pos[2]);
      wrap_done = 1'b0;
      // z innermost, then y, then x
      pz++;
      if (pz >= int'(box_hi[2])) begin
        pz = int'(box_lo[2]);
        py++;
        if (py >= int'(box_hi[1])) begin
          py = int'(box_lo[1]);
          px++;
          if (px >= int'(box_hi[0])) begin
            px = int'(box_lo[0]);
            wrap_done = 1'b1;
          end
        end
      end
      scan_pos[0] = POS_W'(px);
      scan_pos[1] = POS_W'(py);
      scan_pos[2] = POS_W'(pz);
      if (wrap_done) begin
        scan_on = 1'b0;
        res.done = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input voxel_write_t want,
                                 input voxel_write_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s: want we=%0b x=%0d y=%0d z=%0d dens=%0d done=%0b",
               $realtime, what, want.we, want.vx, want.vy, want.vz, want.dens,
               want.done);
      $display("    got we=%0b x=%0d y=%0d z=%0d dens=%0d done=%0b",
               got.we, got.vx, got.vy, got.vz, got.dens, got.done);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one beat per pending item, with a random gap, possibly none, after each
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drv_item = pending_items.pop_front();
        s_axis_tdata <= {3'b000, drv_item.bz, drv_item.by, drv_item.bx, drv_item.lod};
        s_axis_tuser <= drv_item.kind;
        s_axis_tvalid <= 1'b1;
        send_gap <= no_gaps ? 0 : $urandom_range(0, 3);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted input beat, checks every result beat,
  // and may deassert m_axis_tready at random after each result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        mon_item.kind = item_kind_t'(s_axis_tuser);
        mon_item.lod  = s_axis_tdata[3:0];
        mon_item.bx   = s_axis_tdata[30:4];
        mon_item.by   = s_axis_tdata[57:31];
        mon_item.bz   = s_axis_tdata[84:58];
        predict_voxel(mon_item, mon_want);
        pending_writes.push_back(mon_want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        mon_got.we   = m_axis_tuser;
        mon_got.vx   = m_axis_tdata[5:0];
        mon_got.vy   = m_axis_tdata[11:6];
        mon_got.vz   = m_axis_tdata[17:12];
        mon_got.dens = m_axis_tdata[25:18];
        mon_got.done = m_axis_tlast;
        if (pending_writes.size() == 0) begin
          report_mismatch("unexpected result beat", '0, mon_got);
        end else begin
          mon_want = pending_writes.pop_front();
          if (mon_got.we !== mon_want.we || mon_got.vx !== mon_want.vx ||
              mon_got.vy !== mon_want.vy || mon_got.vz !== mon_want.vz ||
              mon_got.dens !== mon_want.dens || mon_got.done !== mon_want.done)
            report_mismatch("result mismatch", mon_want, mon_got);
        end
        mon_stall = no_gaps ? 0 : $urandom_range(0, 3);
        recv_wait <= mon_stall;
        m_axis_tready <= (mon_stall == 0);
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        m_axis_tready <= (recv_wait == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTER_X: cfg_center[0] = val;
      REG_CENTER_Y: cfg_center[1] = val;
      REG_CENTER_Z: cfg_center[2] = val;
      REG_RADIUS:   cfg_radius = val[15:0];
      REG_DENSITY:  cfg_density = val[7:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry junk on the narrow registers
  task automatic load_sphere(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cz, input logic [15:0] r,
                             input logic [7:0] dens);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, {16'($urandom), r});
    write_reg(REG_DENSITY, {24'($urandom), dens});
  endtask

  // sender holds off until the core has returned everything
  task automatic wait_drained();
    while (pending_items.size() != 0 || s_axis_tvalid || pending_writes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic scan_item_t start_item(input logic [3:0] l, input logic [26:0] x,
                                            input logic [26:0] y, input logic [26:0] z);
    scan_item_t it;
    it.kind = KIND_START;
    it.lod = l;
    it.bx = x;
    it.by = y;
    it.bz = z;
    return it;
  endfunction

  // tick beats carry random junk in the unused fields
  function automatic scan_item_t tick_item();
    scan_item_t it;
    it.kind = KIND_TICK;
    it.lod = 4'($urandom_range(0, 15));
    it.bx = 27'($urandom);
    it.by = 27'($urandom);
    it.bz = 27'($urandom);
    return it;
  endfunction

  // Random scans: a start aimed at (or next to) the block holding the sphere,
  // then about one box worth of ticks; some runs are cut short or overrun.
  task automatic queue_scan_phase(input int budget);
    logic [26:0] bpos [3];
    longint      q, base;
    int          count, lmin, a, i, sel, r, vol, n;
    count = 0;
    while (count < budget) begin
      // smallest lod that keeps the scaled radius at 3 or less
      lmin = 0;
      while (lmin < 15 && (cfg_radius >> lmin) > 3) lmin++;
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 15);
      end else begin
        a = lmin + $urandom_range(0, 2);
        if (a > 15) a = 15;
      end
      for (i = 0; i < 3; i++) begin
        q = longint'(cfg_center[i]) / (longint'(1) << a);
        base = q >>> 5;
        sel = $urandom_range(0, 9);
        if (sel <= 5) bpos[i] = 27'(base);
        else if (sel <= 7) bpos[i] = 27'(base - 1);   // sphere near the upper face
        else if (sel == 8) bpos[i] = 27'(base + 1);
        else bpos[i] = 27'($urandom);                 // almost surely rejected
      end
      pending_items.push_back(start_item(4'(a), bpos[0], bpos[1], bpos[2]));
      r = int'(cfg_radius >> a);
      if (r > 3) begin
        n = $urandom_range(0, 20);
      end else begin
        vol = 8 * r * r * r;
        if ($urandom_range(0, 3) != 0) n = vol + $urandom_range(0, 2);
        else n = $urandom_range(0, vol);
      end
      repeat (n) pending_items.push_back(tick_item());
      count += 1 + n;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: idle tick, zero-radius start (empty box), then another idle tick
    pending_items.push_back(tick_item());
    pending_items.push_back(start_item(4'd0, 27'd0, 27'd0, 27'd0));
    pending_items.push_back(tick_item());
    wait_drained();

    // small sphere in block 0: 2x2x2 box, only the center voxel is written
    load_sphere(32'sd10, 32'sd10, 32'sd10, 16'd1, 8'hA5);
    pending_items.push_back(start_item(4'd0, 27'd0, 27'd0, 27'd0));
    repeat (9) pending_items.push_back(tick_item());   // last one finds the scan idle
    // far block and the extreme lod / block positions: rejected
    pending_items.push_back(start_item(4'd0, 27'sd1000, -27'sd1000, 27'd0));
    pending_items.push_back(start_item(4'd15, 27'h4000000, 27'h3FFFFFF, 27'h4000000));
    // restart in the middle of a scan
    pending_items.push_back(start_item(4'd0, 27'd0, 27'd0, 27'd0));
    repeat (3) pending_items.push_back(tick_item());
    pending_items.push_back(start_item(4'd0, 27'd0, 27'd0, 27'd0));
    repeat (2) pending_items.push_back(tick_item());
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: load_sphere(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 8'hFF);
        1: load_sphere($urandom_range(0, 128) - 64, $urandom_range(0, 128) - 64,
                       $urandom_range(0, 128) - 64, 16'($urandom_range(1, 6)), 8'h00);
        default: load_sphere($urandom, $urandom, $urandom,
                             16'($urandom >> $urandom_range(16, 31)), 8'($urandom));
      endcase
      no_gaps = (p == 5);
      queue_scan_phase(PHASE_BUDGET);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_writes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: voxel_sphere_fill_scanner_core.f
design/vsf_pkg.sv
design/voxel_sphere_fill_scanner_core.sv
design/vsf_checker.sv
test/voxel_sphere_fill_scanner_core_tb.sv
